### design/lzrc_pkg.sv
// ----------------------------------------------------------------------------
// lzrc_pkg
// Shared types and constants of the LZ range coder decompressor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lzrc_pkg;

  localparam int unsigned WINDOW_SIZE = 65536;
  localparam int unsigned CTX_COUNT   = 256;
  localparam int unsigned FREQ_DEPTH  = 65536;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] RANGE_TOP   = 32'h0100_0000;
  localparam logic [31:0] RANGE_INIT  = 32'hFFFF_FFFF;
  localparam logic [15:0] TOTAL_INIT  = 16'h0100;
  localparam logic [15:0] END_OFFSET  = 16'h0100;
  localparam logic [15:0] COPY_BIAS   = 16'd259;
  localparam logic [8:0]  RUN_BIAS    = 9'd4;
  localparam logic [8:0]  RUN_MAX     = 9'd259;
  localparam logic [7:0]  FILL_BYTE   = 8'hFF;
  localparam logic [3:0]  FLAG_TOKENS = 4'd8;

  typedef enum logic [1:0] {
    CMD_SUPPLY = 2'd0,
    CMD_PULL   = 2'd1,
    CMD_START  = 2'd2,
    CMD_UNUSED = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    OP_SUPPLY,
    OP_PULL,
    OP_START,
    OP_BAD
  } op_e;

  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_NEED    = 3'd1,
    ST_END     = 3'd2,
    ST_CORRUPT = 3'd3,
    ST_ACCEPT  = 3'd4,
    ST_REJECT  = 3'd5,
    ST_STARTED = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    STOP_RUN     = 2'd0,
    STOP_END     = 2'd1,
    STOP_CORRUPT = 2'd2
  } stop_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PULL,
    S_D_TOT,
    S_D_NORM,
    S_D_DIV1,
    S_D_DIV2,
    S_D_SRD,
    S_D_SACC,
    S_D_UPD1,
    S_D_UPD2,
    S_D_RSRD,
    S_D_RSWR,
    S_CP_RD,
    S_CP_WR
  } state_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_in;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data_out;
  } out_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [31:0] low;
    logic [31:0] value;
    logic [31:0] range;
    logic [15:0] wpos;
    logic [15:0] csrc;
    logic [8:0]  run_left;
    logic        fill;
    logic [7:0]  flags;
    logic [3:0]  flags_left;
    logic [7:0]  mf0;
    logic [7:0]  mf1;
    logic [7:0]  mf2;
    logic [2:0]  phase;
    logic [7:0]  held;
    logic        held_valid;
    logic [1:0]  stop;
    logic [7:0]  last;
    logic [7:0]  ctx;
    logic [15:0] fc;
    logic [15:0] q;
    logic [7:0]  k;
    logic [24:0] s;
    logic [15:0] f;
    logic [15:0] clr;
  } regs_t;

endpackage

`default_nettype wire

### design/lzrc_fifo.sv
// ----------------------------------------------------------------------------
// lzrc_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzrc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### design/lzrc_front.sv
// ----------------------------------------------------------------------------
// lzrc_front
// Takes input words, decodes the command and queues it for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzrc_front #(
  parameter int unsigned QueueDepth = lzrc_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lzrc_pkg::in_t  item_i,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire logic           hold_i,
  output lzrc_pkg::cmd_t      cmd_o,
  output logic                cmd_valid_o,
  input  wire logic           cmd_pop_i
);
  import lzrc_pkg::*;

  cmd_t cmd_in;
  logic q_full, q_empty;
  logic [$bits(cmd_t)-1:0] q_out;

  always_comb begin
    cmd_in.data = item_i.data_in;
    unique case (command_e'(item_i.command))
      CMD_SUPPLY: cmd_in.op = OP_SUPPLY;
      CMD_PULL:   cmd_in.op = OP_PULL;
      CMD_START:  cmd_in.op = OP_START;
      default:    cmd_in.op = OP_BAD;
    endcase
  end

  // No word is taken while the engine sweeps its tables.
  assign full_o = q_full || hold_i;

  lzrc_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QueueDepth)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && !full_o),
    .data_i (cmd_in),
    .full_o (q_full),
    .pop_i  (cmd_pop_i),
    .data_o (q_out),
    .empty_o(q_empty)
  );

  assign cmd_o       = cmd_t'(q_out);
  assign cmd_valid_o = !q_empty;

endmodule

`default_nettype wire

### design/lzrc_divider.sv
// ----------------------------------------------------------------------------
// lzrc_divider
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzrc_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quotient_o
);

  logic [31:0] quo_q, rem_q, div_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] rem_sh, trial;

  assign rem_sh = {rem_q, quo_q[31]};
  assign trial  = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### design/lzrc_engine.sv
// ----------------------------------------------------------------------------
// lzrc_engine
// Executes queued commands: range decoding, model update and byte output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzrc_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lzrc_pkg::cmd_t cmd_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output lzrc_pkg::out_t      res_o,
  output logic                clearing_o
);
  import lzrc_pkg::*;

  localparam regs_t RegsInit = '{
    low: '0, value: '0, range: RANGE_INIT, wpos: '0, csrc: 16'hFFFF,
    run_left: '0, fill: 1'b0, flags: '0, flags_left: '0,
    mf0: '0, mf1: '0, mf2: '0, phase: '0, held: '0, held_valid: 1'b0,
    stop: STOP_RUN, last: FILL_BYTE, ctx: '0, fc: '0, q: '0, k: '0,
    s: '0, f: '0, clr: '0
  };

  state_e state_q, state_d;
  regs_t  regs_q, regs_d;

  // Memories.
  logic [15:0] freq_mem [FREQ_DEPTH];
  logic [7:0]  hist_mem [WINDOW_SIZE];
  logic [15:0] tot_mem  [CTX_COUNT];
  logic [15:0] freq_rd_q, freq_wd, tot_rd_q, tot_wd;
  logic [7:0]  hist_rd_q, hist_wd;
  logic [15:0] freq_wa, hist_wa;
  logic [7:0]  tot_wa;
  logic        freq_we, hist_we, tot_we;

  // Divider.
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_quo;

  // Combinational helpers.
  logic        emit, dec_ok;
  status_e     emit_st;
  logic [7:0]  emit_data, sym, byte_out, resc;
  logic [31:0] low_sh, range_sh, lr_sum, prod_low, prod_range;
  logic [24:0] s_next;
  logic [15:0] fc_inc, off, fc_sum;
  logic        need_norm;

  assign low_sh     = {regs_q.low[23:0], 8'h00};
  assign range_sh   = {regs_q.range[23:0], 8'h00};
  assign lr_sum     = regs_q.low + regs_q.range;
  assign need_norm  = (regs_q.value < regs_q.low) || ((regs_q.low ^ lr_sum) < RANGE_TOP) ||
                      (regs_q.range < {16'h0000, tot_rd_q});
  assign s_next     = regs_q.s + {9'd0, freq_rd_q};
  assign prod_low   = regs_q.range * {16'h0000, (regs_q.s[15:0] - regs_q.f)};
  assign prod_range = regs_q.range * {16'h0000, regs_q.f};
  assign fc_inc     = regs_q.fc + 16'd1;
  assign resc       = 8'h00;
  assign fc_sum     = regs_q.fc + ({1'b0, freq_rd_q[15:1]} | {15'd0, freq_rd_q[0]});

  lzrc_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      regs_q  <= RegsInit;
    end else begin
      state_q <= state_d;
      regs_q  <= regs_d;
    end
  end

  // Read addresses follow the live registers; read data is registered.
  always_ff @(posedge clk_i) begin
    if (freq_we) begin
      freq_mem[freq_wa] <= freq_wd;
    end
    freq_rd_q <= freq_mem[{regs_q.ctx, regs_q.k}];
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_q <= hist_mem[regs_q.csrc];
    if (tot_we) begin
      tot_mem[tot_wa] <= tot_wd;
    end
    tot_rd_q <= tot_mem[regs_q.ctx];
  end

  always_comb begin
    state_d    = state_q;
    regs_d     = regs_q;
    cmd_pop_o  = 1'b0;
    emit       = 1'b0;
    emit_st    = ST_BYTE;
    emit_data  = 8'h00;
    dec_ok     = 1'b0;
    sym        = regs_q.k;
    byte_out   = resc;
    off        = '0;
    div_start  = 1'b0;
    div_a      = regs_q.range;
    div_b      = {16'h0000, tot_rd_q};
    freq_we    = 1'b0;
    freq_wa    = {regs_q.ctx, regs_q.k};
    freq_wd    = regs_q.f + 16'd1;
    hist_we    = 1'b0;
    hist_wa    = regs_q.wpos;
    hist_wd    = regs_q.csrc[7:0];
    tot_we     = 1'b0;
    tot_wa     = regs_q.ctx;
    tot_wd     = fc_inc;

    unique case (state_q)
      S_CLEAR: begin
        freq_we = 1'b1;
        freq_wa = regs_q.clr;
        freq_wd = 16'd1;
        hist_we = 1'b1;
        hist_wa = regs_q.clr;
        hist_wd = FILL_BYTE;
        tot_we  = 1'b1;
        tot_wa  = regs_q.clr[7:0];
        tot_wd  = TOTAL_INIT;
        regs_d.clr = regs_q.clr + 16'd1;
        if (regs_q.clr == 16'hFFFF) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_SUPPLY: begin
              emit = 1'b1;
              if (regs_q.held_valid) begin
                emit_st = ST_REJECT;
              end else begin
                emit_st           = ST_ACCEPT;
                regs_d.held       = cmd_i.data;
                regs_d.held_valid = 1'b1;
              end
            end
            OP_PULL: begin
              if (regs_q.stop == STOP_END) begin
                emit    = 1'b1;
                emit_st = ST_END;
              end else if (regs_q.stop != STOP_RUN) begin
                emit    = 1'b1;
                emit_st = ST_CORRUPT;
              end else begin
                state_d = S_PULL;
              end
            end
            OP_START: begin
              emit    = 1'b1;
              emit_st = ST_STARTED;
              regs_d  = RegsInit;
            end
            default: begin
              emit    = 1'b1;
              emit_st = ST_REJECT;
            end
          endcase
        end
      end

      S_PULL: begin
        if (regs_q.phase < 3'd4) begin
          if (!regs_q.held_valid) begin
            emit    = 1'b1;
            emit_st = ST_NEED;
          end else begin
            regs_d.value      = {regs_q.value[23:0], regs_q.held};
            regs_d.held_valid = 1'b0;
            regs_d.phase      = regs_q.phase + 3'd1;
          end
        end else if (regs_q.run_left != '0) begin
          if (regs_q.fill) begin
            byte_out        = regs_q.csrc[7:0];
            hist_we         = 1'b1;
            hist_wd         = byte_out;
            regs_d.last     = byte_out;
            regs_d.wpos     = regs_q.wpos + 16'd1;
            regs_d.run_left = regs_q.run_left - 9'd1;
            emit            = 1'b1;
            emit_data       = byte_out;
          end else begin
            state_d = S_CP_RD;
          end
        end else if (regs_q.phase == 3'd4) begin
          if (regs_q.flags_left == '0) begin
            regs_d.ctx = 8'd0;
            state_d    = S_D_TOT;
          end else if (regs_q.flags[7]) begin
            regs_d.ctx = regs_q.last;
            state_d    = S_D_TOT;
          end else begin
            regs_d.phase = 3'd5;
          end
        end else begin
          regs_d.ctx = {5'd0, regs_q.phase - 3'd4};
          state_d    = S_D_TOT;
        end
      end

      S_D_TOT: begin
        state_d = S_D_NORM;
      end

      S_D_NORM: begin
        if (tot_rd_q == '0) begin
          emit        = 1'b1;
          emit_st     = ST_CORRUPT;
          regs_d.stop = STOP_CORRUPT;
        end else if (need_norm) begin
          if (!regs_q.held_valid) begin
            emit    = 1'b1;
            emit_st = ST_NEED;
          end else begin
            regs_d.held_valid = 1'b0;
            regs_d.value      = {regs_q.value[23:0], regs_q.held};
            regs_d.low        = low_sh;
            regs_d.range      = (range_sh > ~low_sh) ? ~low_sh : range_sh;
          end
        end else begin
          regs_d.fc = tot_rd_q;
          div_start = 1'b1;
          state_d   = S_D_DIV1;
        end
      end

      S_D_DIV1: begin
        if (div_done) begin
          regs_d.range = div_quo;
          div_start    = 1'b1;
          div_a        = regs_q.value - regs_q.low;
          div_b        = div_quo;
          state_d      = S_D_DIV2;
        end
      end

      S_D_DIV2: begin
        if (div_done) begin
          if (div_quo >= {16'h0000, regs_q.fc}) begin
            emit        = 1'b1;
            emit_st     = ST_CORRUPT;
            regs_d.stop = STOP_CORRUPT;
          end else begin
            regs_d.q = div_quo[15:0];
            regs_d.k = '0;
            regs_d.s = '0;
            state_d  = S_D_SRD;
          end
        end
      end

      S_D_SRD: begin
        state_d = S_D_SACC;
      end

      S_D_SACC: begin
        if (s_next > {9'd0, regs_q.q}) begin
          regs_d.s = s_next;
          regs_d.f = freq_rd_q;
          state_d  = S_D_UPD1;
        end else if (regs_q.k == 8'hFF) begin
          emit        = 1'b1;
          emit_st     = ST_CORRUPT;
          regs_d.stop = STOP_CORRUPT;
        end else begin
          regs_d.s = s_next;
          regs_d.k = regs_q.k + 8'd1;
          state_d  = S_D_SRD;
        end
      end

      S_D_UPD1: begin
        // The symbol's cumulative base stays below the total, so 16 bits hold it.
        regs_d.low = regs_q.low + prod_low;
        state_d    = S_D_UPD2;
      end

      S_D_UPD2: begin
        regs_d.range = prod_range;
        freq_we      = 1'b1;
        if (fc_inc == '0) begin
          regs_d.fc  = '0;
          regs_d.f   = {8'd0, regs_q.k};
          regs_d.k   = '0;
          state_d    = S_D_RSRD;
        end else begin
          tot_we = 1'b1;
          dec_ok = 1'b1;
        end
      end

      S_D_RSRD: begin
        state_d = S_D_RSWR;
      end

      S_D_RSWR: begin
        // Halve each count, keeping the low bit so no count drops to zero.
        freq_we   = 1'b1;
        freq_wd   = {1'b0, freq_rd_q[15:1]} | {15'd0, freq_rd_q[0]};
        regs_d.fc = fc_sum;
        if (regs_q.k == 8'hFF) begin
          tot_we = 1'b1;
          tot_wd = fc_sum;
          sym    = regs_q.f[7:0];
          dec_ok = 1'b1;
        end else begin
          regs_d.k = regs_q.k + 8'd1;
          state_d  = S_D_RSRD;
        end
      end

      S_CP_RD: begin
        state_d = S_CP_WR;
      end

      S_CP_WR: begin
        byte_out        = hist_rd_q;
        hist_we         = 1'b1;
        hist_wd         = byte_out;
        regs_d.last     = byte_out;
        regs_d.csrc     = regs_q.csrc + 16'd1;
        regs_d.wpos     = regs_q.wpos + 16'd1;
        regs_d.run_left = regs_q.run_left - 9'd1;
        emit            = 1'b1;
        emit_data       = byte_out;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A decoded symbol lands according to the token phase.
    if (dec_ok) begin
      state_d = S_PULL;
      if (regs_q.phase == 3'd4) begin
        if (regs_q.flags_left == '0) begin
          regs_d.flags      = sym;
          regs_d.flags_left = FLAG_TOKENS;
        end else begin
          regs_d.csrc       = {regs_q.csrc[15:8], sym};
          regs_d.run_left   = 9'd1;
          regs_d.fill       = 1'b1;
          regs_d.flags      = {regs_q.flags[6:0], 1'b0};
          regs_d.flags_left = regs_q.flags_left - 4'd1;
        end
      end else if (regs_q.phase == 3'd5) begin
        regs_d.mf0   = sym;
        regs_d.phase = 3'd6;
      end else if (regs_q.phase == 3'd6) begin
        regs_d.mf1   = sym;
        regs_d.phase = 3'd7;
      end else begin
        regs_d.mf2   = sym;
        regs_d.phase = 3'd4;
        off          = {sym, regs_q.mf1};
        if (off == END_OFFSET) begin
          regs_d.stop = STOP_END;
          emit        = 1'b1;
          emit_st     = ST_END;
        end else begin
          regs_d.fill = 1'b1;
          if (off > END_OFFSET) begin
            off         = ~off + regs_q.wpos + COPY_BIAS;
            regs_d.fill = 1'b0;
          end
          regs_d.csrc       = off;
          regs_d.run_left   = RUN_BIAS + {1'b0, regs_q.mf0};
          regs_d.flags      = {regs_q.flags[6:0], 1'b0};
          regs_d.flags_left = regs_q.flags_left - 4'd1;
        end
      end
    end

    if (emit) begin
      state_d = (emit_st == ST_STARTED) ? S_CLEAR : S_IDLE;
    end
  end

  assign res_push_o     = emit;
  assign res_o.status   = emit_st;
  assign res_o.data_out = (emit_st == ST_BYTE) ? emit_data : 8'h00;
  assign clearing_o     = (state_q == S_CLEAR);

  logic in_decode;
  assign in_decode = (state_q != S_CLEAR) && (state_q != S_IDLE) &&
                     (state_q != S_PULL) && (state_q != S_CP_RD) && (state_q != S_CP_WR);

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (cmd_valid_i && state_q == S_IDLE))
    else $error("command taken outside idle");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!res_push_o && !cmd_pop_o))
    else $error("activity during table sweep");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    regs_q.run_left <= RUN_MAX)
    else $error("run length out of range");

  a_decode_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_decode |-> (regs_q.phase >= 3'd4 && regs_q.stop == STOP_RUN))
    else $error("symbol decode before priming or after stop");

endmodule

`default_nettype wire

### design/lz_range_coder_decompressor_core.sv
// ----------------------------------------------------------------------------
// lz_range_coder_decompressor_core
// LZ decompressor with an order-1 adaptive carryless range decoder.
// ----------------------------------------------------------------------------
// Every input word (supply, pull or start) yields exactly one result word, in
// order. Words enter a short command queue; a separate engine executes them and
// places results into a result queue, so the two sides stall independently.
// After reset and after every start command the engine sweeps its count and
// window memories, one entry per cycle, over 65536 addresses; full stays high
// during that sweep. Supply and start words are finished in the cycle that the
// engine takes them from the queue. A pull is taken from the queue in idle; a
// fill or literal byte from a pending run is then emitted in the pull state, a
// window copy byte in a write state after a read state. A pull that decodes a
// range-coded symbol reads the context total, normalizes one held byte at a
// time, runs two 32-bit divisions in the shared bit-serial divider, visits the
// counts in a linear symbol search (read and accumulate per count, up to 256)
// and updates in S_D_UPD1 and S_D_UPD2; when a context total wraps, a rescale
// pass rewrites all 256 counts of the context. A single pull may decode several
// symbols (flag byte, then the three match symbols) before it yields its byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lz_range_coder_decompressor_core #(
  parameter int unsigned QueueDepth = lzrc_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lzrc_pkg::in_t  item_i,
  input  wire logic           push,
  output logic                full,
  output lzrc_pkg::out_t      result_o,
  output logic                empty,
  input  wire logic           pop
);
  import lzrc_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  logic clearing;
  logic res_full, res_push;
  out_t res;
  logic [$bits(out_t)-1:0] res_q_out;

  // Front: command decode and input queue.
  lzrc_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .push_i     (push),
    .full_o     (full),
    .hold_i     (clearing),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop)
  );

  // Back: the decoder engine with its models and history window.
  lzrc_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res),
    .clearing_o (clearing)
  );

  // Result queue: a finished word waits here while the engine moves on.
  lzrc_fifo #(
    .WIDTH($bits(out_t)),
    .DEPTH(QueueDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_q_out),
    .empty_o(empty)
  );

  assign result_o = out_t'(res_q_out);

endmodule

`default_nettype wire

### bench/lzrc_checker.sv
// ----------------------------------------------------------------------------
// lzrc_checker
// Watches both queue channels of the decompressor, predicts every result word
// from the accepted input words and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzrc_checker
  import lzrc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  item_i,
  input  logic push_i,
  input  logic full_i,
  input  out_t result_i,
  input  logic empty_i,
  input  logic pop_i,
  output int   fail_o,
  output int   pending_o
);

  typedef enum int {RC_OK, RC_NEED, RC_BAD} sym_rc_e;

  logic [15:0] cnt_mem [FREQ_DEPTH];
  logic [15:0] ctx_total [CTX_COUNT];
  logic [7:0]  hist [WINDOW_SIZE];
  logic [31:0] c_low, c_val, c_rng;
  logic [15:0] wpos, csrc;
  logic [8:0]  run_left;
  logic        fill;
  logic [7:0]  flags, flags_left;
  logic [7:0]  mf [3];
  logic [2:0]  phase;
  logic [7:0]  held;
  logic        held_ok;
  stop_e       stop;
  out_t        want_words [$];

  task automatic stream_start();
    for (int i = 0; i < FREQ_DEPTH; i++) cnt_mem[i] = 16'd1;
    for (int i = 0; i < CTX_COUNT; i++) ctx_total[i] = TOTAL_INIT;
    for (int i = 0; i < WINDOW_SIZE; i++) hist[i] = FILL_BYTE;
    c_low = '0;
    c_val = '0;
    c_rng = RANGE_INIT;
    wpos = '0;
    csrc = 16'hFFFF;
    run_left = '0;
    fill = 1'b0;
    flags = '0;
    flags_left = '0;
    mf[0] = '0;
    mf[1] = '0;
    mf[2] = '0;
    phase = '0;
    held = '0;
    held_ok = 1'b0;
    stop = STOP_RUN;
  endtask

  task automatic range_decode(input logic [7:0] ctx, output logic [7:0] sym,
                              output sym_rc_e rc);
    logic [31:0] fc, q, s, f;
    int k;
    sym = '0;
    rc = RC_OK;
    fc = 32'(ctx_total[ctx]);
    if (fc == 0) begin
      rc = RC_BAD;
      return;
    end
    while (c_val < c_low || (c_low ^ (c_low + c_rng)) < RANGE_TOP || c_rng < fc) begin
      if (!held_ok) begin
        rc = RC_NEED;
        return;
      end
      held_ok = 1'b0;
      c_val = {c_val[23:0], held};
      c_low = c_low << 8;
      c_rng = c_rng << 8;
      if (c_rng > ~c_low) c_rng = ~c_low;
    end
    c_rng = c_rng / fc;
    q = (c_val - c_low) / c_rng;
    if (q >= fc) begin
      rc = RC_BAD;
      return;
    end
    s = '0;
    for (k = 0; k < 256; k++) begin
      s = s + 32'(cnt_mem[{ctx, 8'(k)}]);
      if (s > q) break;
    end
    if (k >= 256) begin
      rc = RC_BAD;
      return;
    end
    f = 32'(cnt_mem[{ctx, 8'(k)}]);
    c_low = c_low + (s - f) * c_rng;
    c_rng = c_rng * f;
    cnt_mem[{ctx, 8'(k)}] = 16'(f + 1);
    fc = (fc + 1) & 32'hFFFF;
    if (fc == 0) begin
      // Total wrapped: halve every count but keep it odd-preserving.
      for (int j = 0; j < 256; j++) begin
        f = 32'(cnt_mem[{ctx, 8'(j)}]);
        f = (f >> 1) | (f & 1);
        cnt_mem[{ctx, 8'(j)}] = 16'(f);
        fc = fc + f;
      end
      fc = fc & 32'hFFFF;
    end
    ctx_total[ctx] = 16'(fc);
    sym = 8'(k);
  endtask

  task automatic next_output_byte(output status_e st, output logic [7:0] b);
    logic [7:0] sym;
    logic [15:0] off;
    sym_rc_e rc;
    b = '0;
    st = ST_NEED;
    rc = RC_OK;
    while (phase < 3'd4) begin
      if (!held_ok) return;
      held_ok = 1'b0;
      c_val = {c_val[23:0], held};
      phase = phase + 3'd1;
    end
    while (rc == RC_OK) begin
      if (run_left != 0) begin
        if (fill) begin
          b = csrc[7:0];
        end else begin
          b = hist[csrc];
          csrc = csrc + 16'd1;
        end
        hist[wpos] = b;
        wpos = wpos + 16'd1;
        run_left = run_left - 9'd1;
        st = ST_BYTE;
        return;
      end
      if (phase == 3'd4) begin
        if (flags_left == 0) begin
          range_decode(8'd0, sym, rc);
          if (rc == RC_OK) begin
            flags = sym;
            flags_left = 8'(FLAG_TOKENS);
          end
        end else if (flags[7]) begin
          range_decode(hist[wpos - 16'd1], sym, rc);
          if (rc == RC_OK) begin
            csrc = {csrc[15:8], sym};
            run_left = 9'd1;
            fill = 1'b1;
            flags = flags << 1;
            flags_left = flags_left - 8'd1;
          end
        end else begin
          phase = 3'd5;
        end
      end else begin
        range_decode(8'(phase) - 8'd4, sym, rc);
        if (rc == RC_OK) begin
          mf[phase - 3'd5] = sym;
          if (phase < 3'd7) begin
            phase = phase + 3'd1;
          end else begin
            phase = 3'd4;
            off = {mf[2], mf[1]};
            fill = 1'b1;
            if (off >= END_OFFSET) begin
              if (off == END_OFFSET) begin
                stop = STOP_END;
                st = ST_END;
                return;
              end
              off = ~off + wpos + COPY_BIAS;
              fill = 1'b0;
            end
            csrc = off;
            run_left = RUN_BIAS + 9'(mf[0]);
            flags = flags << 1;
            flags_left = flags_left - 8'd1;
          end
        end
      end
    end
    if (rc == RC_BAD) begin
      stop = STOP_CORRUPT;
      st = ST_CORRUPT;
    end
  endtask

  task automatic predict_word(input in_t w, output out_t res);
    status_e st;
    logic [7:0] b;
    b = '0;
    case (command_e'(w.command))
      CMD_SUPPLY: begin
        if (held_ok) begin
          st = ST_REJECT;
        end else begin
          held = w.data_in;
          held_ok = 1'b1;
          st = ST_ACCEPT;
        end
      end
      CMD_PULL: begin
        if (stop == STOP_END) st = ST_END;
        else if (stop != STOP_RUN) st = ST_CORRUPT;
        else next_output_byte(st, b);
      end
      CMD_START: begin
        stream_start();
        st = ST_STARTED;
      end
      default: st = ST_REJECT;
    endcase
    res.status = st;
    res.data_out = (st == ST_BYTE) ? b : 8'd0;
  endtask

  initial begin
    fail_o = 0;
    pending_o = 0;
    stream_start();
  end

  always @(posedge clk_i) begin
    out_t want, got;
    if (rst_ni) begin
      if (pop_i && !empty_i) begin
        got = result_i;
        if (want_words.size() == 0) begin
          fail_o++;
          if (fail_o <= 10)
            $display("unexpected result word: status %0d data %02h", got.status,
                     got.data_out);
        end else begin
          want = want_words.pop_front();
          if (got.status != want.status || got.data_out != want.data_out) begin
            fail_o++;
            if (fail_o <= 10)
              $display("mismatch at %0t: status exp %0d got %0d, data exp %02h got %02h",
                       $realtime, want.status, got.status, want.data_out, got.data_out);
          end
        end
      end
      if (push_i && !full_i) begin
        predict_word(item_i, want);
        want_words.push_back(want);
      end
      pending_o = want_words.size();
    end
  end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the LZ range coder decompressor core.
// ----------------------------------------------------------------------------
// The bench feeds supply, pull and start words through the input queue and
// drains result words with a randomly stalling receiver. A checker beside the
// block predicts every result word and counts mismatches. The directed part
// covers rejects, the lacking-byte case, a corrupt stream, an end marker and a
// fill run; the latter two come from a small encoder for fresh contexts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lzrc_pkg::*;

  localparam int unsigned LIMIT = 20_000_000;

  logic clk_i;
  logic rst_ni;
  in_t  item;
  logic push;
  logic full;
  out_t result;
  logic empty;
  logic pop;

  int fails;
  int pending;
  int cycles;
  int tx_idle_pct;
  int rx_stall_pct;
  bit hold_req;

  lz_range_coder_decompressor_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .push     (push),
    .full     (full),
    .result_o (result),
    .empty    (empty),
    .pop      (pop)
  );

  lzrc_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .push_i    (push),
    .full_i    (full),
    .result_i  (result),
    .empty_i   (empty),
    .pop_i     (pop),
    .fail_o    (fails),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The watchdog covers the memory sweeps after every start as well as the
  // slowest symbol decodes; anything beyond it means the block is stuck.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver. It pops at random, and on request it holds off for a long
  // stretch so that both queues fill and full pushes back on the sender.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        for (int n = 0; n < 400; n++) @(posedge clk_i);
        hold_req = 1'b0;
      end
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offers one word and returns at the edge where it is taken. Full is read
  // right after the edge, before the block's own updates land, so it is the
  // value the handshake saw.
  task automatic put(input command_e c, input logic [7:0] d);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    item <= '{command: c, data_in: d};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Each compressed byte is followed by a pull, which is how a host would
  // drive the decoder when it streams data in.
  task automatic feed(input logic [7:0] d);
    put(CMD_SUPPLY, d);
    put(CMD_PULL, 8'h00);
  endtask

  // Carryless range encoding of four symbols, each in a fresh context with
  // flat counts: flag byte in context 0, then length and the two offset bytes
  // in contexts 1 to 3. Good enough to build a real match token.
  function automatic void encode_match(input logic [7:0] len, input logic [15:0] off,
                                       ref logic [7:0] bytes [$]);
    logic [31:0] low, rng;
    logic [7:0] syms [4];
    low = '0;
    rng = RANGE_INIT;
    syms[0] = 8'h00;
    syms[1] = len;
    syms[2] = off[7:0];
    syms[3] = off[15:8];
    for (int i = 0; i < 4; i++) begin
      while ((low ^ (low + rng)) < RANGE_TOP || rng < 32'd256) begin
        bytes.push_back(low[31:24]);
        low = low << 8;
        rng = rng << 8;
        if (rng > ~low) rng = ~low;
      end
      rng = rng / 32'd256;
      low = low + 32'(syms[i]) * rng;
    end
    for (int i = 0; i < 4; i++) begin
      bytes.push_back(low[31:24]);
      low = low << 8;
    end
  endfunction

  initial begin
    logic [7:0] stream [$];
    int r;
    cycles = 0;
    hold_req = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    push <= 1'b0;
    item <= '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Pull before priming, unused command, supply while the holding register
    // is full, then a stream of all-ones bytes which scales past the total.
    put(CMD_PULL, 8'h00);
    put(CMD_UNUSED, 8'hA5);
    put(CMD_SUPPLY, 8'hFF);
    put(CMD_SUPPLY, 8'h00);
    put(CMD_PULL, 8'h00);
    feed(8'hFF);
    feed(8'hFF);
    feed(8'hFF);
    put(CMD_PULL, 8'h00);
    put(CMD_SUPPLY, 8'h5A);

    // End marker: a match token whose offset is exactly 0x100.
    put(CMD_START, 8'h00);
    encode_match(8'h07, END_OFFSET, stream);
    foreach (stream[i]) feed(stream[i]);
    put(CMD_PULL, 8'h00);

    // Fill run of six bytes, then whatever the trailing bytes decode to.
    stream.delete();
    put(CMD_START, 8'h00);
    encode_match(8'h02, 16'h0041, stream);
    foreach (stream[i]) feed(stream[i]);
    repeat (8) put(CMD_PULL, 8'h00);

    // Random part in three idling phases, each on a fresh stream.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 56 : 0;
      rx_stall_pct = (ph == 0) ? 56 : (ph == 1) ? 16 : 0;
      put(CMD_START, 8'h00);
      for (int i = 0; i < 160; i++) begin
        if (ph == 0 && i == 20) hold_req = 1'b1;
        if (ph == 1 && i == 80) begin
          // The checker counts the last accepted word at this same edge, so
          // the count is read from the next edge on.
          push <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        r = $urandom_range(99);
        if (r < 45) put(CMD_SUPPLY, 8'($urandom_range(255)));
        else if (r < 96) put(CMD_PULL, 8'($urandom_range(255)));
        else put(CMD_UNUSED, 8'($urandom_range(255)));
      end
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
